### sv/parallel_camera_pixel_capture_defines.svh
// Assertion helpers for the checker file of the capture block.
`ifndef PARALLEL_CAMERA_PIXEL_CAPTURE_DEFINES_SVH
`define PARALLEL_CAMERA_PIXEL_CAPTURE_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PCC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define PCC_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/pcc_pkg.sv
`timescale 1ns / 1ps

package pcc_pkg;

    // Width of the column and row counters inside the sequencer.
    localparam int COUNTER_BITS = 10;

    // Fixed field widths.
    localparam int REG_W   = 10;
    localparam int FIELD_W = 10;
    localparam int BYTE_W  = 8;
    localparam int PIXEL_W = 2 * BYTE_W;

    // Compare width wide enough for count + 1 and for a register value.
    localparam int CMP_W = (COUNTER_BITS + 1 > REG_W) ? COUNTER_BITS + 1 : REG_W;

    // Stream widths, padded to whole bytes.
    localparam int IN_FIELDS_W  = 3 + BYTE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * FIELD_W + PIXEL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [0:0] {
        CFG_PIXELS_PER_LINE = 1'b0,
        CFG_LINES_PER_FRAME = 1'b1
    } t_cfg_idx;

    localparam logic [REG_W-1:0] PIXELS_PER_LINE_RST = REG_W'(320);
    localparam logic [REG_W-1:0] LINES_PER_FRAME_RST = REG_W'(240);

    typedef struct packed {
        logic              vsync;
        logic              href;
        logic              pclk;
        logic [BYTE_W-1:0] bus_byte;
    } t_sample;

    typedef struct packed {
        logic [FIELD_W-1:0] column;
        logic [FIELD_W-1:0] row;
        logic [PIXEL_W-1:0] pixel_value;
        logic               frame_last;
    } t_pixel;

    typedef struct packed {
        logic   valid;
        t_pixel pixel;
    } t_pixel_res;

    // A run ends once count + 1 reaches the limit, or the counter is full.
    function automatic logic count_done(input logic [COUNTER_BITS-1:0] count,
                                        input logic [REG_W-1:0] limit);
        logic [CMP_W-1:0] inc;
        inc = CMP_W'(count) + CMP_W'(1);
        return (inc >= CMP_W'(limit)) || (count == {COUNTER_BITS{1'b1}});
    endfunction

    function automatic logic [FIELD_W-1:0] cnt_to_field(input logic [COUNTER_BITS-1:0] c);
        logic [CMP_W-1:0] e;
        e = CMP_W'(c);
        return e[FIELD_W-1:0];
    endfunction

endpackage

### sv/pcc_in_reg.sv
`timescale 1ns / 1ps

module pcc_in_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [pcc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                         i_down_ready,
    output logic                         o_take,
    output pcc_pkg::t_sample             o_sample
);
    import pcc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_sample r_sample;
    logic    w_accept;

    assign o_take        = r_valid && i_down_ready;
    assign s_axis_tready = !r_valid || i_down_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_sample      = r_sample;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_accept) begin
            r_sample.vsync    <= s_axis_tdata[0];
            r_sample.href     <= s_axis_tdata[1];
            r_sample.pclk     <= s_axis_tdata[2];
            r_sample.bus_byte <= s_axis_tdata[3 +: BYTE_W];
        end
    end

endmodule

### sv/pcc_seq.sv
`timescale 1ns / 1ps

module pcc_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [pcc_pkg::REG_W-1:0] i_cfg_wdata,
    input  logic                      i_take,
    input  pcc_pkg::t_sample          i_sample,
    output pcc_pkg::t_pixel_res       o_res
);
    import pcc_pkg::*;

    typedef enum logic [3:0] {
        PH_VS_HIGH   = 4'd0,
        PH_VS_LOW    = 4'd1,
        PH_HREF_HIGH = 4'd2,
        PH_PCLK_HI1  = 4'd3,
        PH_PCLK_LO1  = 4'd4,
        PH_PCLK_HI2  = 4'd5,
        PH_PCLK_LO2  = 4'd6,
        PH_HREF_LOW  = 4'd7,
        PH_VS_END    = 4'd8
    } t_phase;

    t_phase                  r_phase;
    t_phase                  n_phase;
    logic [COUNTER_BITS-1:0] r_col;
    logic [COUNTER_BITS-1:0] n_col;
    logic [COUNTER_BITS-1:0] r_row;
    logic [COUNTER_BITS-1:0] n_row;
    logic [BYTE_W-1:0]       r_low;
    logic [BYTE_W-1:0]       n_low;
    logic [REG_W-1:0]        r_ppl;
    logic [REG_W-1:0]        r_lpf;
    logic                    w_col_done;
    logic                    w_row_done;

    assign w_col_done = count_done(r_col, r_ppl);
    assign w_row_done = count_done(r_row, r_lpf);

    always_comb begin
        n_phase = r_phase;
        n_col   = r_col;
        n_row   = r_row;
        n_low   = r_low;
        o_res.valid             = 1'b0;
        o_res.pixel.column      = cnt_to_field(r_col);
        o_res.pixel.row         = cnt_to_field(r_row);
        o_res.pixel.pixel_value = {i_sample.bus_byte, r_low};
        o_res.pixel.frame_last  = w_col_done && w_row_done;
        if (i_take) begin
            unique case (r_phase)
                PH_VS_HIGH: begin
                    if (i_sample.vsync) n_phase = PH_VS_LOW;
                end
                PH_VS_LOW: begin
                    if (!i_sample.vsync) n_phase = PH_HREF_HIGH;
                end
                PH_HREF_HIGH: begin
                    if (i_sample.href) n_phase = PH_PCLK_HI1;
                end
                PH_PCLK_HI1: begin
                    if (i_sample.pclk) begin
                        n_low   = i_sample.bus_byte;
                        n_phase = PH_PCLK_LO1;
                    end
                end
                PH_PCLK_LO1: begin
                    if (!i_sample.pclk) n_phase = PH_PCLK_HI2;
                end
                PH_PCLK_HI2: begin
                    if (i_sample.pclk) begin
                        o_res.valid = 1'b1;
                        n_phase     = PH_PCLK_LO2;
                    end
                end
                PH_PCLK_LO2: begin
                    if (!i_sample.pclk) begin
                        if (w_col_done) begin
                            n_col   = '0;
                            n_phase = PH_HREF_LOW;
                        end else begin
                            n_col   = r_col + COUNTER_BITS'(1);
                            n_phase = PH_PCLK_HI1;
                        end
                    end
                end
                PH_HREF_LOW: begin
                    if (!i_sample.href) begin
                        if (w_row_done) begin
                            n_row   = '0;
                            n_phase = PH_VS_END;
                        end else begin
                            n_row   = r_row + COUNTER_BITS'(1);
                            n_phase = PH_HREF_HIGH;
                        end
                    end
                end
                PH_VS_END: begin
                    if (i_sample.vsync) n_phase = PH_VS_HIGH;
                end
                default: begin
                    // A corrupted phase code falls back to waiting for a frame.
                    n_phase = PH_VS_HIGH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VS_HIGH;
            r_col   <= '0;
            r_row   <= '0;
            r_low   <= '0;
            r_ppl   <= PIXELS_PER_LINE_RST;
            r_lpf   <= LINES_PER_FRAME_RST;
        end else begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            r_low   <= n_low;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_PIXELS_PER_LINE: r_ppl <= i_cfg_wdata;
                    CFG_LINES_PER_FRAME: r_lpf <= i_cfg_wdata;
                endcase
            end
        end
    end

endmodule

### sv/pcc_out_skid.sv
`timescale 1ns / 1ps

module pcc_out_skid (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pcc_pkg::t_pixel i_pixel,
    output logic            o_ready,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output pcc_pkg::t_pixel o_pixel
);
    import pcc_pkg::*;

    logic   r_m_valid;
    logic   r_skid_valid;
    t_pixel r_m_pixel;
    t_pixel r_skid_pixel;
    logic   w_pop;

    assign w_pop         = r_m_valid && m_axis_tready;
    assign o_ready       = !r_skid_valid;
    assign m_axis_tvalid = r_m_valid;
    assign o_pixel       = r_m_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_m_pixel    <= r_skid_pixel;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_m_valid || w_pop) begin
                r_m_pixel <= i_pixel;
                r_m_valid <= 1'b1;
            end else begin
                r_skid_pixel <= i_pixel;
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_m_valid <= 1'b0;
        end
    end

endmodule

### sv/parallel_camera_pixel_capture.sv
`timescale 1ns / 1ps
// A pixel reaches the master side from the transaction that carries its second
// pclk-high sample through the input register, then the output register.
// The block takes one pin sample per cycle while the output skid entry is free;
// the two-entry output stage keeps the slave side open while a pixel waits.
// Reset (i_rst_n low, synchronous): sequencer waits for vsync high, counters cleared,
// pixels_per_line = 320, lines_per_frame = 240, both stream stages empty.

module parallel_camera_pixel_capture (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port: index 0 pixels_per_line, index 1 lines_per_frame.
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [pcc_pkg::REG_W-1:0]       i_cfg_wdata,
    // Pin sample stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: vsync, href, pclk, bus_byte[7:0], zero padding.
    input  logic [pcc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Pixel stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: column[9:0], row[9:0], pixel_value[15:0], zero padding.
    output logic [pcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // frame_last: high on the final pixel of a frame.
    output logic                            m_axis_tlast
);
    import pcc_pkg::*;

    logic       w_take;
    logic       w_out_ready;
    t_sample    w_sample;
    t_pixel_res w_res;
    t_pixel     w_out_pixel;

    // Each accepted transaction is held in the input register until the
    // output stage has room; the sequencer then consumes it.
    pcc_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_down_ready  (w_out_ready),
        .o_take        (w_take),
        .o_sample      (w_sample)
    );

    // The sequencer follows the vsync, href and pclk level waits, latches the
    // two bus bytes of a pixel and tracks column and row. Configuration writes
    // take effect at once.
    pcc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (w_take),
        .i_sample    (w_sample),
        .o_res       (w_res)
    );

    // Output register with a skid entry so a stalled master side does not
    // stop the sequencer until both entries are full.
    pcc_out_skid u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_res.valid),
        .i_pixel       (w_res.pixel),
        .o_ready       (w_out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_pixel       (w_out_pixel)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_out_pixel.pixel_value,
                           w_out_pixel.row, w_out_pixel.column};
    assign m_axis_tlast = w_out_pixel.frame_last;

endmodule

### sv/pcc_chk.sv
`timescale 1ns / 1ps
`include "parallel_camera_pixel_capture_defines.svh"

module pcc_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    // Reset empties the output stage.
    `PCC_ASSERT_RST(a_rst_out_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "pixel valid after reset")

    // Reset empties the input register, so the slave side is open.
    `PCC_ASSERT_RST(a_rst_in_ready, i_clk, !i_rst_n |=> s_axis_tready, "sample side closed after reset")

    // A stalled pixel keeps its contents.
    `PCC_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled pixel changed")

    // Once the master side drains, the skid entry is free and samples flow.
    `PCC_ASSERT_CLK(a_ready_after_drain, i_clk, i_rst_n, $past(m_axis_tready) |-> s_axis_tready, "sample side closed after drain")

endmodule

bind parallel_camera_pixel_capture pcc_chk u_pcc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### test/pixel_capture_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the register port of the capture block, runs its own
// copy of the pin sequencer on every accepted sample and compares each accepted
// pixel with the oldest pixel still owed.
module pixel_capture_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [pcc_pkg::REG_W-1:0]       i_cfg_wdata,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [pcc_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [pcc_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                            i_m_tlast,
    input  logic                            i_run_end,
    output int                              o_pending,
    output int                              o_fail_count
);
    import pcc_pkg::*;

    localparam int CB = COUNTER_BITS;

    typedef enum logic [3:0] {
        SEQ_VS_HI,
        SEQ_VS_LO,
        SEQ_HREF_HI,
        SEQ_PCLK_HI1,
        SEQ_PCLK_LO1,
        SEQ_PCLK_HI2,
        SEQ_PCLK_LO2,
        SEQ_HREF_LO,
        SEQ_VS_END
    } t_seq;

    t_seq              seq;
    logic [CB-1:0]     col_cnt;
    logic [CB-1:0]     row_cnt;
    logic [BYTE_W-1:0] first_byte;
    logic [REG_W-1:0]  line_len;
    logic [REG_W-1:0]  frame_len;
    t_pixel            owed_pixels[$];
    int                mismatches = 0;

    // Pixels still owed count as failures once the run is over.
    assign o_fail_count = mismatches + (i_run_end ? o_pending : 0);

    // A zero limit acts as one; a full counter also ends the run.
    function automatic logic run_complete(input logic [CB-1:0] cnt,
                                          input logic [REG_W-1:0] lim);
        return ((32'(cnt) + 1) >= 32'(lim)) || (&cnt);
    endfunction

    always @(posedge i_clk) begin : track
        logic              vs;
        logic              hr;
        logic              pc;
        logic [BYTE_W-1:0] bus;
        t_pixel            got;
        t_pixel            want;
        t_pixel            made;
        if (!i_rst_n) begin
            seq        = SEQ_VS_HI;
            col_cnt    = '0;
            row_cnt    = '0;
            first_byte = '0;
            line_len   = PIXELS_PER_LINE_RST;
            frame_len  = LINES_PER_FRAME_RST;
            owed_pixels.delete();
        end else begin
            // Results are matched before new samples are predicted, so a pixel
            // can never be matched against an expectation made at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                got.column      = i_m_tdata[FIELD_W-1:0];
                got.row         = i_m_tdata[2*FIELD_W-1:FIELD_W];
                got.pixel_value = i_m_tdata[2*FIELD_W +: PIXEL_W];
                got.frame_last  = i_m_tlast;
                if (owed_pixels.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected pixel col %0d row %0d value %h last %b",
                                 $realtime, got.column, got.row, got.pixel_value,
                                 got.frame_last);
                    mismatches <= mismatches + 1;
                end else begin
                    want = owed_pixels.pop_front();
                    if (got.column !== want.column || got.row !== want.row ||
                        got.pixel_value !== want.pixel_value ||
                        got.frame_last !== want.frame_last) begin
                        if (mismatches < 10)
                            $display({"%0t: pixel mismatch: expected col %0d row %0d ",
                                      "value %h last %b, got col %0d row %0d value %h ",
                                      "last %b"}, $realtime,
                                     want.column, want.row, want.pixel_value,
                                     want.frame_last, got.column, got.row,
                                     got.pixel_value, got.frame_last);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PIXELS_PER_LINE)
                    line_len = i_cfg_wdata;
                else
                    frame_len = i_cfg_wdata;
            end

            if (i_s_tvalid && i_s_tready) begin
                vs  = i_s_tdata[0];
                hr  = i_s_tdata[1];
                pc  = i_s_tdata[2];
                bus = i_s_tdata[3 +: BYTE_W];
                // Each sample moves the sequencer by at most one level wait.
                case (seq)
                    SEQ_VS_HI: if (vs) seq = SEQ_VS_LO;
                    SEQ_VS_LO: if (!vs) seq = SEQ_HREF_HI;
                    SEQ_HREF_HI: if (hr) seq = SEQ_PCLK_HI1;
                    SEQ_PCLK_HI1: begin
                        if (pc) begin
                            first_byte = bus;
                            seq = SEQ_PCLK_LO1;
                        end
                    end
                    SEQ_PCLK_LO1: if (!pc) seq = SEQ_PCLK_HI2;
                    SEQ_PCLK_HI2: begin
                        if (pc) begin
                            made.column      = FIELD_W'(col_cnt);
                            made.row         = FIELD_W'(row_cnt);
                            made.pixel_value = {bus, first_byte};
                            made.frame_last  = run_complete(col_cnt, line_len) &&
                                               run_complete(row_cnt, frame_len);
                            owed_pixels.push_back(made);
                            seq = SEQ_PCLK_LO2;
                        end
                    end
                    SEQ_PCLK_LO2: begin
                        if (!pc) begin
                            if (run_complete(col_cnt, line_len)) begin
                                col_cnt = '0;
                                seq = SEQ_HREF_LO;
                            end else begin
                                col_cnt = col_cnt + CB'(1);
                                seq = SEQ_PCLK_HI1;
                            end
                        end
                    end
                    SEQ_HREF_LO: begin
                        if (!hr) begin
                            if (run_complete(row_cnt, frame_len)) begin
                                row_cnt = '0;
                                seq = SEQ_VS_END;
                            end else begin
                                row_cnt = row_cnt + CB'(1);
                                seq = SEQ_HREF_HI;
                            end
                        end
                    end
                    SEQ_VS_END: if (vs) seq = SEQ_VS_HI;
                    default: seq = SEQ_VS_HI;
                endcase
            end
        end
        o_pending <= owed_pixels.size();
    end

endmodule

### test/parallel_camera_pixel_capture_test.sv
`timescale 1ns / 1ps

// Drives pin samples into the capture block as stream transactions, mostly in
// the shape of real camera frames with random pixel bytes and random level
// hold times, plus noisy and abandoned frames. A checker beside the block
// predicts every pixel; this module only makes stimulus and gives the verdict.
module parallel_camera_pixel_capture_test;
    import pcc_pkg::*;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic                   i_cfg_index   = 1'b0;
    logic [REG_W-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   run_end       = 1'b0;

    int pend;
    int fail_count;

    // Shared knobs of the stimulus: random idling on both sides, the chance that
    // a sample is replaced by random pins, and requests for a long receiver hold.
    bit idle_on     = 1'b1;
    int noise_pct   = 0;
    int stall_asks  = 0;
    int items_sent  = 0;

    // Register values as last written, for sizing the generated frames.
    logic [REG_W-1:0] cur_line  = PIXELS_PER_LINE_RST;
    logic [REG_W-1:0] cur_frame = LINES_PER_FRAME_RST;

    parallel_camera_pixel_capture dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    pixel_capture_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_run_end    (run_end),
        .o_pending    (pend),
        .o_fail_count (fail_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: random back-pressure, none in the quiet phase, and a long hold
    // whenever the stimulus asks for one. The hold is counted here so that the
    // sender keeps offering samples meanwhile and the block backs up.
    int stall_seen = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_seen != stall_asks) begin
            stall_seen = stall_asks;
            stall_left = 300;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_on) begin
            m_axis_tready <= ($urandom_range(99) >= 35);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // A zero count register behaves like a count of one.
    function automatic int effective_size(input logic [REG_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    // Offers one pin sample and returns at the edge where the transaction is
    // accepted. tvalid stays high so the next call can follow back to back;
    // anything that lets time pass afterwards must lower it first.
    task automatic send_pins(input logic vs, input logic hr, input logic pc,
                             input logic [BYTE_W-1:0] pins_byte);
        logic [IN_FIELDS_W-1:0] word;
        if (noise_pct > 0 && $urandom_range(99) < noise_pct)
            word = IN_FIELDS_W'($urandom);
        else
            word = {pins_byte, pc, hr, vs};
        while (idle_on && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(word);
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // One bus byte: pclk high with the byte held, then pclk low.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        repeat ($urandom_range(1, 2)) send_pins(1'b0, 1'b1, 1'b1, b);
        repeat ($urandom_range(1, 2)) send_pins(1'b0, 1'b1, 1'b0, BYTE_W'($urandom));
    endtask

    // A camera frame: vsync pulse, then lines framed by href, two bytes per
    // pixel. A broken frame is abandoned halfway through one of its lines.
    task automatic send_frame(input int ppl, input int lpf, input bit may_break);
        int cut_line;
        cut_line = (may_break && $urandom_range(99) < 30) ? $urandom_range(lpf - 1) : -1;
        repeat ($urandom_range(2, 4))
            send_pins(1'b1, 1'($urandom), 1'($urandom), BYTE_W'($urandom));
        repeat ($urandom_range(1, 3))
            send_pins(1'b0, 1'b0, 1'($urandom), BYTE_W'($urandom));
        for (int ln = 0; ln < lpf; ln++) begin
            repeat ($urandom_range(1, 2))
                send_pins(1'b0, 1'b1, 1'b0, BYTE_W'($urandom));
            for (int px = 0; px < ppl; px++) begin
                if (ln == cut_line && px == ppl / 2)
                    return;
                send_byte(BYTE_W'($urandom));
                send_byte(BYTE_W'($urandom));
            end
            repeat ($urandom_range(1, 2))
                send_pins(1'b0, 1'b0, 1'($urandom), BYTE_W'($urandom));
        end
    endtask

    // Stops offering samples and waits until every predicted pixel has come
    // out, then waits on for any sample still inside the input register.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pend != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Writes one or both registers on consecutive edges; the block is idle.
    task automatic configure(input bit set_line, input bit set_frame,
                             input logic [REG_W-1:0] line_v,
                             input logic [REG_W-1:0] frame_v);
        if (set_line) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_PIXELS_PER_LINE;
            i_cfg_wdata <= line_v;
            cur_line    = line_v;
            @(posedge i_clk);
        end
        if (set_frame) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_LINES_PER_FRAME;
            i_cfg_wdata <= frame_v;
            cur_frame   = frame_v;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int goal;
        int phase_no;
        logic [REG_W-1:0] line_v;
        logic [REG_W-1:0] frame_v;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: the first pixel under the reset sizes, with all-zero and
        // all-one bytes. No line can end yet, so the pixel is not frame-last.
        send_pins(1'b1, 1'b0, 1'b0, 8'h00);
        send_pins(1'b1, 1'b0, 1'b0, 8'h00);
        send_pins(1'b0, 1'b0, 1'b0, 8'hFF);
        send_pins(1'b0, 1'b1, 1'b0, 8'h00);
        send_pins(1'b0, 1'b1, 1'b1, 8'h00);
        send_pins(1'b0, 1'b1, 1'b0, 8'h55);
        send_pins(1'b0, 1'b1, 1'b1, 8'hFF);
        wait_idle();

        // Zero in both registers while the frame is open: the counters are
        // already past the new sizes, so the line and the frame close at once,
        // and the next frame is a single frame-last pixel.
        configure(1'b1, 1'b1, '0, '0);
        send_pins(1'b0, 1'b1, 1'b0, 8'hAA);
        send_pins(1'b0, 1'b0, 1'b0, 8'h00);
        send_pins(1'b1, 1'b0, 1'b0, 8'h00);
        send_pins(1'b1, 1'b0, 1'b0, 8'h00);
        send_pins(1'b0, 1'b0, 1'b0, 8'h00);
        send_pins(1'b0, 1'b1, 1'b0, 8'h00);
        send_pins(1'b0, 1'b1, 1'b1, 8'hFF);
        send_pins(1'b0, 1'b1, 1'b0, 8'h0F);
        send_pins(1'b0, 1'b1, 1'b1, 8'h00);
        send_pins(1'b0, 1'b1, 1'b0, 8'hF0);
        send_pins(1'b0, 1'b0, 1'b0, 8'h00);
        wait_idle();

        // Random part: small frames with random content. Phase 0 carries the
        // long receiver hold, phase 1 runs with no idling on either side, and
        // every fifth phase is noisy with frames that may be cut short.
        goal     = items_sent + 700;
        phase_no = 0;
        while (items_sent < goal) begin
            wait_idle();
            idle_on   = (phase_no != 1);
            noise_pct = (phase_no % 5 == 4) ? 25 : 2;
            if (phase_no == 0) begin
                configure(1'b1, 1'b1, 10'd8, 10'd4);
                stall_asks++;
                send_frame(8, 4, 1'b0);
            end else begin
                line_v  = ($urandom_range(9) == 0) ? REG_W'($urandom_range(7, 16))
                                                   : REG_W'($urandom_range(1, 6));
                frame_v = REG_W'($urandom_range(1, 4));
                if ($urandom_range(15) == 0)
                    line_v = '0;
                if ($urandom_range(15) == 0)
                    frame_v = '0;
                // Often only one register changes, so the other keeps its value
                // across phases.
                case ($urandom_range(2))
                    0: configure(1'b1, 1'b0, line_v, frame_v);
                    1: configure(1'b0, 1'b1, line_v, frame_v);
                    default: configure(1'b1, 1'b1, line_v, frame_v);
                endcase
                repeat ($urandom_range(1, 3))
                    send_frame(effective_size(cur_line), effective_size(cur_frame),
                               noise_pct > 2);
            end
            phase_no++;
        end

        // Drain, then count whatever is still owed and give the verdict.
        wait_idle();
        run_end <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
